@@ src/nfba_pkg.sv @@
// Shared types and constants for the next-fit block allocator.
// Holds the transaction structs, memory control struct and sequencer states.
// No dependencies.
package nfba_pkg;

    localparam int HEAP_WORDS_DEF = 4096;
    localparam int BLOCK_OVERHEAD = 4;
    localparam int REQ_W          = 13;
    localparam int ADDR_W         = 12;
    localparam int CFG_W          = 13;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  req_size;
        logic [ADDR_W-1:0] free_addr;
    } cmd_t;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } result_t;

    typedef struct packed {
        logic en;
        logic we;
    } mem_ctl_t;

    localparam mem_ctl_t MEM_NOP = '{en: 1'b0, we: 1'b0};
    localparam mem_ctl_t MEM_RD  = '{en: 1'b1, we: 1'b0};
    localparam mem_ctl_t MEM_WR  = '{en: 1'b1, we: 1'b1};

    typedef enum logic [5:0] {
        S_IDLE,
        S_CLR, S_CH0, S_CH1, S_CH2, S_CH3,
        S_A_START, S_A_SZ, S_A_NX, S_A_PV,
        S_A_W0, S_A_W1, S_A_W2, S_A_W3, S_A_W4,
        S_A_W5, S_A_W6, S_A_W7, S_A_W8, S_A_W9,
        S_F_START, S_F_SIZE, S_F_FOOT, S_F_LEFT, S_F_WRS0, S_F_WRS1,
        S_F_LB0, S_F_LB1, S_F_LB2, S_F_LM0, S_F_LM1,
        S_F_RB0, S_F_RB1, S_F_RB2, S_F_DC,
        S_F_P0, S_F_P1, S_F_P2,
        S_F_U0, S_F_UH1, S_F_UH2, S_F_UN1, S_F_UN2, S_F_UN3,
        S_F_MS0, S_F_MS1, S_F_MS2, S_F_MS3
    } state_t;

endpackage

@@ src/next_fit_block_allocator.sv @@
// Next-fit block allocator with boundary tags: sequencer plus heap memory.
// Allocate: time from accept to result grows with N, the number of free blocks visited.
// Free: time from accept to result is set by the chain of single-port heap accesses.
// One transaction at a time; busy drops in the result strobe cycle, so the next can start then.
// Reset and every heap_words write run a format sweep.
// The result is shown for one cycle on done; the receiver cannot stall it.
module next_fit_block_allocator #(
    parameter int HEAP_WORDS = nfba_pkg::HEAP_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  nfba_pkg::cmd_t              cmd,
    output logic                        busy,
    output logic                        done,
    output nfba_pkg::result_t           result,
    input  logic                        cfg_we,
    input  logic [nfba_pkg::CFG_W-1:0]  cfg_wdata
);
    import nfba_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = AW + 1;
    localparam int DW = SW + 1;

    mem_ctl_t      mctl;
    logic [SW-1:0] maddr;
    logic [DW-1:0] mwdata;
    logic [DW-1:0] rdata;

    nfba_ctrl #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .mctl      (mctl),
        .maddr     (maddr),
        .mwdata    (mwdata),
        .rdata     (rdata)
    );

    nfba_ram #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_ram (
        .clk   (clk),
        .ctl   (mctl),
        .addr  (maddr),
        .wdata (mwdata),
        .rdata (rdata)
    );

endmodule

@@ src/nfba_ram.sv @@
// Heap word memory: single port, synchronous read; read data is valid in the cycle after the read.
// Addresses past the heap read as zero and drop writes. Uses nfba_pkg.
module nfba_ram #(
    parameter int HEAP_WORDS = nfba_pkg::HEAP_WORDS_DEF
) (
    input  logic                                clk,
    input  nfba_pkg::mem_ctl_t                  ctl,
    input  logic [$clog2(HEAP_WORDS):0]         addr,
    input  logic [$clog2(HEAP_WORDS)+1:0]       wdata,
    output logic [$clog2(HEAP_WORDS)+1:0]       rdata
);
    import nfba_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = AW + 1;
    localparam int DW = SW + 1;

    logic [DW-1:0] mem [HEAP_WORDS];
    logic [DW-1:0] rd_reg;
    logic          oob_reg;
    logic          in_range;

    assign in_range = (addr < SW'(HEAP_WORDS));

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                if (in_range)
                begin
                    mem[addr[AW-1:0]] <= wdata;
                end
            end
            else
            begin
                rd_reg  <= mem[addr[AW-1:0]];
                oob_reg <= !in_range;
            end
        end
    end

    assign rdata = oob_reg ? '0 : rd_reg;

endmodule

@@ src/nfba_ctrl.sv @@
// Allocator sequencer: next-fit search, split/unlink, free with coalescing,
// heap format sweep. Drives the heap memory in nfba_ram. Uses nfba_pkg.
module nfba_ctrl #(
    parameter int HEAP_WORDS = nfba_pkg::HEAP_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  nfba_pkg::cmd_t                      cmd,
    output logic                                busy,
    output logic                                done,
    output nfba_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [nfba_pkg::CFG_W-1:0]          cfg_wdata,
    output nfba_pkg::mem_ctl_t                  mctl,
    output logic [$clog2(HEAP_WORDS):0]         maddr,
    output logic [$clog2(HEAP_WORDS)+1:0]       mwdata,
    input  logic [$clog2(HEAP_WORDS)+1:0]       rdata
);
    import nfba_pkg::*;

    localparam int AW = $clog2(HEAP_WORDS);
    localparam int SW = AW + 1;
    localparam int DW = SW + 1;
    localparam int CW = ((SW > REQ_W) ? SW : REQ_W) + 2;

    localparam logic [SW-1:0] NIL   = '1;
    localparam logic [SW-1:0] ONE   = SW'(1);
    localparam logic [SW-1:0] TWO   = SW'(2);
    localparam logic [CW-1:0] OVH_C = CW'(BLOCK_OVERHEAD);
    localparam logic [CW-1:0] HW_C  = CW'(HEAP_WORDS);

    function automatic logic [DW-1:0] lword(input logic [SW-1:0] l);
        return {l[SW-1], l};
    endfunction

    function automatic logic [DW-1:0] sword(input logic [SW-1:0] s);
        return {1'b0, s};
    endfunction

    state_t        state_reg, state_next;
    logic [SW-1:0] clr_reg, clr_next;
    logic [SW-1:0] hw_reg, hw_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] rover_reg, rover_next;
    logic          done_reg, done_next;
    result_t       res_reg, res_next;
    cmd_t          cmd_reg, cmd_next;
    logic [SW-1:0] need_reg, need_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic          found_reg, found_next;
    logic [SW-1:0] bs_reg, bs_next;
    logic [SW-1:0] nb_reg, nb_next;
    logic [SW-1:0] pb_reg, pb_next;
    logic [SW-1:0] guard_reg, guard_next;
    logic          split_reg, split_next;
    logic [SW-1:0] rem_reg, rem_next;
    logic [SW-1:0] rs_reg, rs_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] f_reg, f_next;
    logic [SW-1:0] left_reg, left_next;
    logic [SW-1:0] right_reg, right_next;
    logic          mleft_reg, mleft_next;
    logic          mright_reg, mright_next;
    logic [SW-1:0] tmp_reg, tmp_next;
    logic [SW-1:0] nr_reg, nr_next;

    logic [CW-1:0] rdata_c;
    logic [CW-1:0] hw_c;
    logic [CW-1:0] req_c;
    logic [CW-1:0] fcw;
    logic [SW-1:0] rd_link;
    logic [SW-1:0] nc;
    logic [SW-1:0] sum;

    assign rdata_c = CW'(rdata);
    assign hw_c    = CW'(hw_reg);
    assign req_c   = CW'(cmd_reg.req_size);
    assign fcw     = CW'(cmd_reg.free_addr) - CW'(3);
    assign rd_link = rdata[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            hw_reg    <= SW'(HEAP_WORDS);
            head_reg  <= NIL;
            rover_reg <= NIL;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            hw_reg    <= hw_next;
            head_reg  <= head_next;
            rover_reg <= rover_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        cmd_reg    <= cmd_next;
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        found_reg  <= found_next;
        bs_reg     <= bs_next;
        nb_reg     <= nb_next;
        pb_reg     <= pb_next;
        guard_reg  <= guard_next;
        split_reg  <= split_next;
        rem_reg    <= rem_next;
        rs_reg     <= rs_next;
        s_reg      <= s_next;
        f_reg      <= f_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        mleft_reg  <= mleft_next;
        mright_reg <= mright_next;
        tmp_reg    <= tmp_next;
        nr_reg     <= nr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        hw_next     = hw_reg;
        head_next   = head_reg;
        rover_next  = rover_reg;
        done_next   = 1'b0;
        res_next    = res_reg;
        cmd_next    = cmd_reg;
        need_next   = need_reg;
        cur_next    = cur_reg;
        found_next  = found_reg;
        bs_next     = bs_reg;
        nb_next     = nb_reg;
        pb_next     = pb_reg;
        guard_next  = guard_reg;
        split_next  = split_reg;
        rem_next    = rem_reg;
        rs_next     = rs_reg;
        s_next      = s_reg;
        f_next      = f_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        mleft_next  = mleft_reg;
        mright_next = mright_reg;
        tmp_next    = tmp_reg;
        nr_next     = nr_reg;
        mctl        = MEM_NOP;
        maddr       = '0;
        mwdata      = '0;
        nc          = rd_link;
        sum         = tmp_reg + rdata[SW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = (cmd.action == ACT_FREE) ? S_F_START : S_A_START;
                end
            end

            // format sweep: zero every word, then lay down one free block if heap_words exceeds the overhead
            S_CLR:
            begin
                mctl     = MEM_WR;
                maddr    = clr_reg;
                clr_next = clr_reg + ONE;
                if (clr_reg == SW'(HEAP_WORDS - 1))
                begin
                    if (hw_c > OVH_C)
                    begin
                        state_next = S_CH0;
                    end
                    else
                    begin
                        head_next  = NIL;
                        rover_next = NIL;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CH0:
            begin
                mctl       = MEM_WR;
                maddr      = '0;
                mwdata     = sword(hw_reg);
                state_next = S_CH1;
            end
            S_CH1:
            begin
                mctl       = MEM_WR;
                maddr      = hw_reg - ONE;
                mwdata     = sword(hw_reg);
                state_next = S_CH2;
            end
            S_CH2:
            begin
                mctl       = MEM_WR;
                maddr      = ONE;
                mwdata     = lword(NIL);
                state_next = S_CH3;
            end
            S_CH3:
            begin
                mctl       = MEM_WR;
                maddr      = TWO;
                mwdata     = lword(NIL);
                head_next  = '0;
                rover_next = '0;
                state_next = S_IDLE;
            end

            // ---------------- allocate ----------------
            S_A_START:
            begin
                need_next = SW'(req_c + OVH_C);
                if (req_c == '0 || hw_c <= OVH_C || req_c > hw_c - OVH_C
                    || rover_reg == NIL)
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cur_next   = rover_reg;
                    guard_next = '0;
                    mctl       = MEM_RD;
                    maddr      = rover_reg;
                    state_next = S_A_SZ;
                end
            end
            S_A_SZ:
            begin
                found_next = (rdata_c >= CW'(need_reg));
                bs_next    = rdata[SW-1:0];
                mctl       = MEM_RD;
                maddr      = cur_reg + ONE;
                state_next = S_A_NX;
            end
            S_A_NX:
            begin
                if (found_reg)
                begin
                    nb_next    = rd_link;
                    mctl       = MEM_RD;
                    maddr      = cur_reg + TWO;
                    state_next = S_A_PV;
                end
                else
                begin
                    // wrap once to the list head when the rover was not the head
                    if (rd_link == NIL && rover_reg != head_reg)
                    begin
                        nc = head_reg;
                    end
                    if (nc == rover_reg || nc == NIL || guard_reg == SW'(HEAP_WORDS))
                    begin
                        done_next  = 1'b1;
                        res_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cur_next   = nc;
                        guard_next = guard_reg + ONE;
                        mctl       = MEM_RD;
                        maddr      = nc;
                        state_next = S_A_SZ;
                    end
                end
            end
            S_A_PV:
            begin
                pb_next    = rd_link;
                split_next = (CW'(bs_reg) > CW'(need_reg) + OVH_C);
                rem_next   = cur_reg + need_reg;
                rs_next    = bs_reg - need_reg;
                if (CW'(bs_reg) > CW'(need_reg) + OVH_C)
                begin
                    s_next = need_reg;
                    if (rd_link == NIL)
                    begin
                        head_next = cur_reg + need_reg;
                    end
                    rover_next = (nb_reg != NIL) ? nb_reg :
                                 ((rd_link == NIL) ? cur_reg + need_reg : head_reg);
                end
                else
                begin
                    s_next = bs_reg;
                    if (rd_link == NIL)
                    begin
                        head_next = nb_reg;
                    end
                    rover_next = (nb_reg != NIL) ? nb_reg :
                                 ((rd_link == NIL) ? nb_reg : head_reg);
                end
                state_next = S_A_W0;
            end
            S_A_W0:
            begin
                if (split_reg)
                begin
                    mctl   = MEM_WR;
                    maddr  = rem_reg;
                    mwdata = sword(rs_reg);
                end
                state_next = S_A_W1;
            end
            S_A_W1:
            begin
                if (split_reg)
                begin
                    mctl   = MEM_WR;
                    maddr  = cur_reg + bs_reg - ONE;
                    mwdata = sword(rs_reg);
                end
                state_next = S_A_W2;
            end
            S_A_W2:
            begin
                if (split_reg)
                begin
                    mctl   = MEM_WR;
                    maddr  = rem_reg + ONE;
                    mwdata = lword(nb_reg);
                end
                state_next = S_A_W3;
            end
            S_A_W3:
            begin
                if (split_reg)
                begin
                    mctl   = MEM_WR;
                    maddr  = rem_reg + TWO;
                    mwdata = lword(pb_reg);
                end
                state_next = S_A_W4;
            end
            S_A_W4:
            begin
                if (pb_reg != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = pb_reg + ONE;
                    mwdata = lword(split_reg ? rem_reg : nb_reg);
                end
                state_next = S_A_W5;
            end
            S_A_W5:
            begin
                if (nb_reg != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = nb_reg + TWO;
                    mwdata = lword(split_reg ? rem_reg : pb_reg);
                end
                state_next = S_A_W6;
            end
            S_A_W6:
            begin
                mctl       = MEM_WR;
                maddr      = cur_reg;
                mwdata     = sword(s_reg);
                state_next = S_A_W7;
            end
            S_A_W7:
            begin
                mctl       = MEM_WR;
                maddr      = cur_reg + s_reg - ONE;
                mwdata     = {1'b1, s_reg};
                state_next = S_A_W8;
            end
            S_A_W8:
            begin
                mctl       = MEM_WR;
                maddr      = cur_reg + ONE;
                mwdata     = lword(NIL);
                state_next = S_A_W9;
            end
            S_A_W9:
            begin
                mctl          = MEM_WR;
                maddr         = cur_reg + TWO;
                mwdata        = lword(NIL);
                done_next     = 1'b1;
                res_next.ok   = 1'b1;
                res_next.addr = ADDR_W'(CW'(cur_reg) + CW'(3));
                state_next    = S_IDLE;
            end

            // ---------------- free ----------------
            S_F_START:
            begin
                if (CW'(cmd_reg.free_addr) < CW'(3) || fcw >= hw_c)
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    f_next     = SW'(fcw);
                    mctl       = MEM_RD;
                    maddr      = SW'(fcw);
                    state_next = S_F_SIZE;
                end
            end
            S_F_SIZE:
            begin
                if (rdata_c < OVH_C || rdata_c > hw_c - CW'(f_reg))
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    s_next     = rdata[SW-1:0];
                    mctl       = MEM_RD;
                    maddr      = f_reg + rdata[SW-1:0] - ONE;
                    state_next = S_F_FOOT;
                end
            end
            S_F_FOOT:
            begin
                mleft_next  = 1'b0;
                mright_next = 1'b0;
                right_next  = (CW'(f_reg) + CW'(s_reg) < hw_c) ? f_reg + s_reg : NIL;
                if (rdata != {1'b1, s_reg})
                begin
                    done_next  = 1'b1;
                    res_next   = '0;
                    state_next = S_IDLE;
                end
                else if (f_reg != '0)
                begin
                    mctl       = MEM_RD;
                    maddr      = f_reg - ONE;
                    state_next = S_F_LEFT;
                end
                else
                begin
                    left_next  = NIL;
                    state_next = S_F_WRS0;
                end
            end
            S_F_LEFT:
            begin
                // flag bit dropped: footer word gives the left block size
                if (CW'(rdata[SW-1:0]) >= OVH_C && rdata[SW-1:0] <= f_reg)
                begin
                    left_next = f_reg - rdata[SW-1:0];
                end
                else
                begin
                    left_next = NIL;
                end
                state_next = S_F_WRS0;
            end
            S_F_WRS0:
            begin
                mctl       = MEM_WR;
                maddr      = f_reg;
                mwdata     = sword(s_reg);
                state_next = S_F_WRS1;
            end
            S_F_WRS1:
            begin
                mctl       = MEM_WR;
                maddr      = f_reg + s_reg - ONE;
                mwdata     = sword(s_reg);
                state_next = (left_reg != NIL) ? S_F_LB0 : S_F_RB0;
            end
            S_F_LB0:
            begin
                mctl       = MEM_RD;
                maddr      = left_reg;
                state_next = S_F_LB1;
            end
            S_F_LB1:
            begin
                if (rdata_c >= OVH_C && rdata_c <= hw_c - CW'(left_reg))
                begin
                    tmp_next   = rdata[SW-1:0];
                    mctl       = MEM_RD;
                    maddr      = left_reg + rdata[SW-1:0] - ONE;
                    state_next = S_F_LB2;
                end
                else
                begin
                    state_next = S_F_RB0;
                end
            end
            S_F_LB2:
            begin
                state_next = (rdata == sword(tmp_reg)) ? S_F_LM0 : S_F_RB0;
            end
            S_F_LM0:
            begin
                mctl       = MEM_WR;
                maddr      = left_reg;
                mwdata     = sword(tmp_reg + s_reg);
                tmp_next   = tmp_reg + s_reg;
                state_next = S_F_LM1;
            end
            S_F_LM1:
            begin
                mctl       = MEM_WR;
                maddr      = left_reg + tmp_reg - ONE;
                mwdata     = sword(tmp_reg);
                f_next     = left_reg;
                mleft_next = 1'b1;
                state_next = S_F_RB0;
            end
            S_F_RB0:
            begin
                if (right_reg == NIL)
                begin
                    state_next = S_F_DC;
                end
                else
                begin
                    mctl       = MEM_RD;
                    maddr      = right_reg;
                    state_next = S_F_RB1;
                end
            end
            S_F_RB1:
            begin
                if (rdata_c >= OVH_C && rdata_c <= hw_c - CW'(right_reg))
                begin
                    tmp_next   = rdata[SW-1:0];
                    mctl       = MEM_RD;
                    maddr      = right_reg + rdata[SW-1:0] - ONE;
                    state_next = S_F_RB2;
                end
                else
                begin
                    state_next = S_F_DC;
                end
            end
            S_F_RB2:
            begin
                if (rdata == sword(tmp_reg))
                begin
                    mright_next = 1'b1;
                    state_next  = mleft_reg ? S_F_U0 : S_F_P0;
                end
                else
                begin
                    state_next = S_F_DC;
                end
            end
            S_F_DC:
            begin
                if (mleft_reg)
                begin
                    done_next  = 1'b1;
                    res_next   = '{ok: 1'b1, addr: '0};
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_F_P0;
                end
            end
            // push f at the list head
            S_F_P0:
            begin
                mctl       = MEM_WR;
                maddr      = f_reg + ONE;
                mwdata     = lword(head_reg);
                state_next = S_F_P1;
            end
            S_F_P1:
            begin
                if (head_reg != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = head_reg + TWO;
                    mwdata = lword(f_reg);
                end
                else if (!mright_reg)
                begin
                    rover_next = f_reg;
                end
                state_next = S_F_P2;
            end
            S_F_P2:
            begin
                mctl      = MEM_WR;
                maddr     = f_reg + TWO;
                mwdata    = lword(NIL);
                head_next = f_reg;
                if (mright_reg)
                begin
                    state_next = S_F_U0;
                end
                else
                begin
                    done_next  = 1'b1;
                    res_next   = '{ok: 1'b1, addr: '0};
                    state_next = S_IDLE;
                end
            end
            // unlink the right neighbor
            S_F_U0:
            begin
                mctl       = MEM_RD;
                maddr      = right_reg + ONE;
                state_next = (right_reg == head_reg) ? S_F_UH1 : S_F_UN1;
            end
            S_F_UH1:
            begin
                head_next  = rd_link;
                state_next = S_F_UH2;
            end
            S_F_UH2:
            begin
                if (head_reg != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = head_reg + TWO;
                    mwdata = lword(NIL);
                end
                state_next = S_F_MS0;
            end
            S_F_UN1:
            begin
                nr_next    = rd_link;
                mctl       = MEM_RD;
                maddr      = right_reg + TWO;
                state_next = S_F_UN2;
            end
            S_F_UN2:
            begin
                pb_next = rd_link;
                if (rd_link != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = rd_link + ONE;
                    mwdata = lword(nr_reg);
                end
                state_next = S_F_UN3;
            end
            S_F_UN3:
            begin
                if (nr_reg != NIL)
                begin
                    mctl   = MEM_WR;
                    maddr  = nr_reg + TWO;
                    mwdata = lword(pb_reg);
                end
                state_next = S_F_MS0;
            end
            // grow f by the right block
            S_F_MS0:
            begin
                mctl       = MEM_RD;
                maddr      = f_reg;
                state_next = S_F_MS1;
            end
            S_F_MS1:
            begin
                tmp_next   = rdata[SW-1:0];
                mctl       = MEM_RD;
                maddr      = right_reg;
                state_next = S_F_MS2;
            end
            S_F_MS2:
            begin
                mctl       = MEM_WR;
                maddr      = f_reg;
                mwdata     = sword(sum);
                tmp_next   = sum;
                state_next = S_F_MS3;
            end
            S_F_MS3:
            begin
                mctl   = MEM_WR;
                maddr  = f_reg + tmp_reg - ONE;
                mwdata = sword(tmp_reg);
                if (rover_reg == right_reg)
                begin
                    rover_next = f_reg;
                end
                done_next  = 1'b1;
                res_next   = '{ok: 1'b1, addr: '0};
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write reformats the heap
        if (cfg_we)
        begin
            hw_next    = (CW'(cfg_wdata) > HW_C) ? SW'(HEAP_WORDS) : SW'(cfg_wdata);
            clr_next   = '0;
            done_next  = 1'b0;
            state_next = S_CLR;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer active");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held over two cycles");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !mctl.en)
        else $error("heap access while idle");

endmodule
